// ----- hdl/float_to_decimal_decompose_unit_macros.svh -----
// Assertion macros for the binary32 to decimal decomposition block.
// Included by the top level; depends on nothing else.
`ifndef FLOAT_TO_DECIMAL_DECOMPOSE_UNIT_MACROS_SVH
`define FLOAT_TO_DECIMAL_DECOMPOSE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FTDD_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTDD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ftdd_pkg.sv -----
// Shared types and constants for the binary32 to decimal decomposition block.
// No dependencies.
`timescale 1ns / 1ps

package ftdd_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_FINITE = 3'd0;
    localparam logic [2:0] KIND_ZERO   = 3'd1;
    localparam logic [2:0] KIND_PINF   = 3'd2;
    localparam logic [2:0] KIND_NINF   = 3'd3;
    localparam logic [2:0] KIND_NAN    = 3'd4;

    // Scaling window as binary32 bit patterns (1e7 and 1e6).
    localparam logic [31:0] WIN_HIGH_BITS = 32'h4B18_9680;
    localparam logic [31:0] WIN_LOW_BITS  = 32'h4974_2400;

    localparam logic [6:0]  STEP_BUDGET   = 7'd64;
    localparam logic [24:0] WIN_HIGH_INT  = 25'd10000000;
    localparam logic [24:0] WIN_LOW_INT   = 25'd1000000;

    // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x.
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [31:0] TEN         = 32'd10;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CHECK = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_PACK  = 8'b0000_1000,
        ST_ROUND = 8'b0001_0000,
        ST_NORM  = 8'b0010_0000,
        ST_NDIV  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

endpackage

// ----- hdl/float_to_decimal_decompose_unit.sv -----
// Top level of the binary32 to decimal decomposition block.
// Depends on ftdd_pkg and float_to_decimal_decompose_unit_macros.svh.
`timescale 1ns / 1ps
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata) takes one raw binary32 word
// per request. The master channel (m_tvalid, m_tready, m_tdata) returns one
// result per request: the kind, a signed seven-digit mantissa and a decimal
// exponent. NaN, infinities and zeros are classified at once and their result
// is offered in the cycle after acceptance. A finite word is scaled into
// [1e6, 1e7) by repeated binary32 multiply or divide by ten. Each scaling step
// compares against the window, forms a product on the shared 32x32 multiplier
// and then normalizes and rounds the product. At most 64 steps run (51 for the
// smallest subnormal, 32 for the largest normal). A final window check, rounding
// and renormalization follow before a finite result is offered. One request is
// in flight at a time: s_tready is high only while the block is idle. A
// synchronous active-low reset returns the sequencer to idle and drops m_tvalid.
// While the receiver holds m_tready low the result stays on m_tdata unchanged
// and no new request is taken.

`include "float_to_decimal_decompose_unit_macros.svh"

module float_to_decimal_decompose_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] float_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [2:0] value_kind, [27:3] decimal_mantissa,
                                   // [34:28] decimal_exponent, [39:35] zero
);

    ftdd_pkg::state_t state_reg, state_next;

    logic [31:0]       mag_reg, mag_next;      // current magnitude, binary32
    logic              neg_reg, neg_next;
    logic              down_reg, down_next;    // step direction: divide by ten
    logic signed [7:0] exp_reg, exp_next;
    logic [6:0]        steps_reg, steps_next;
    logic [63:0]       prod_reg, prod_next;
    logic [24:0]       mant_reg, mant_next;
    logic [2:0]        kind_reg, kind_next;

    // Fields of the incoming word.
    logic [7:0] in_ebits;
    logic       in_fnz;
    assign in_ebits = s_tdata[30:23];
    assign in_fnz   = (s_tdata[22:0] != 23'd0);

    // Fields of the current magnitude.
    logic [7:0]  cur_e;
    logic [7:0]  cur_e_eff;
    logic [23:0] cur_sig;
    assign cur_e     = mag_reg[30:23];
    assign cur_e_eff = (cur_e == 8'd0) ? 8'd1 : cur_e;
    assign cur_sig   = {(cur_e != 8'd0), mag_reg[22:0]};

    // Shared multiplier operands.
    logic [31:0] mul_a, mul_b;
    always_comb begin
        if (state_reg == ftdd_pkg::ST_NORM) begin
            mul_a = {7'd0, mant_reg};
            mul_b = ftdd_pkg::RECIP_TEN;
        end else if (down_reg) begin
            mul_a = {3'd0, cur_sig, 5'd0};
            mul_b = ftdd_pkg::RECIP_TEN;
        end else begin
            mul_a = {8'd0, cur_sig};
            mul_b = ftdd_pkg::TEN;
        end
    end

    // Divide step: quotient of (sig << 5) / 10, sticky from the remainder.
    // The quotient of a normal significand has its top bit at 25 or 24.
    logic [28:0] dq;
    logic [31:0] dq_times10;
    logic        d_sticky;
    logic [23:0] d_sig;
    logic        d_guard, d_low;
    logic [7:0]  d_e;
    assign dq         = prod_reg[63:ftdd_pkg::RECIP_SHIFT];
    assign dq_times10 = {dq, 3'd0} + {2'd0, dq, 1'b0};
    assign d_sticky   = (dq_times10 != {3'd0, cur_sig, 5'd0});

    always_comb begin
        if (dq[25]) begin
            d_sig   = dq[25:2];
            d_guard = dq[1];
            d_low   = dq[0] | d_sticky;
            d_e     = cur_e - 8'd3;
        end else begin
            d_sig   = dq[24:1];
            d_guard = dq[0];
            d_low   = d_sticky;
            d_e     = cur_e - 8'd4;
        end
    end

    // Multiply step: sig * 10, renormalized; small results stay subnormal.
    logic [27:0] up_p;
    logic [23:0] u_sig;
    logic        u_guard, u_low;
    logic [7:0]  u_k;
    assign up_p = prod_reg[27:0];

    always_comb begin
        u_guard = 1'b0;
        u_low   = 1'b0;
        priority if (up_p[27]) begin
            u_sig = up_p[27:4]; u_guard = up_p[3]; u_low = (up_p[2:0] != 3'd0); u_k = 8'd4;
        end else if (up_p[26]) begin
            u_sig = up_p[26:3]; u_guard = up_p[2]; u_low = (up_p[1:0] != 2'd0); u_k = 8'd3;
        end else if (up_p[25]) begin
            u_sig = up_p[25:2]; u_guard = up_p[1]; u_low = up_p[0]; u_k = 8'd2;
        end else if (up_p[24]) begin
            u_sig = up_p[24:1]; u_guard = up_p[0]; u_k = 8'd1;
        end else begin
            u_sig = up_p[23:0]; u_k = 8'd0;
        end
    end

    // Round to nearest even; the carry out of the fraction bumps the exponent.
    logic [30:0] packed_bits;
    always_comb begin
        if (down_reg) begin
            packed_bits = {d_e, d_sig[22:0]}
                        + {30'd0, d_guard & (d_low | d_sig[0])};
        end else if (!up_p[23] && (up_p[27:24] == 4'd0)) begin
            // Still subnormal (or just reaching the normal range): exact.
            packed_bits = {7'd0, up_p[23:0]};
        end else begin
            packed_bits = {cur_e_eff + u_k, u_sig[22:0]}
                        + {30'd0, u_guard & (u_low | u_sig[0])};
        end
    end

    // mag + 0.5 then truncate for magnitudes in [2^19, 2^23); in [2^23, 2^24) an odd magnitude gets one added.
    logic [24:0] round_int;
    logic [24:0] sig25;
    assign sig25 = {1'b0, cur_sig};
    always_comb begin
        unique case (cur_e)
            8'd150:  round_int = sig25 + {24'd0, cur_sig[0]};
            8'd149:  round_int = (sig25 + 25'd1) >> 1;
            8'd148:  round_int = (sig25 + 25'd2) >> 2;
            8'd147:  round_int = (sig25 + 25'd4) >> 3;
            default: round_int = (sig25 + 25'd8) >> 4;
        endcase
    end

    logic steps_left;
    assign steps_left = (steps_reg < ftdd_pkg::STEP_BUDGET);

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        down_next  = down_reg;
        exp_next   = exp_reg;
        steps_next = steps_reg;
        prod_next  = prod_reg;
        mant_next  = mant_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ftdd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    neg_next   = s_tdata[31];
                    mag_next   = {1'b0, s_tdata[30:0]};
                    exp_next   = 8'sd0;
                    steps_next = 7'd0;
                    mant_next  = 25'd0;
                    if (in_ebits == 8'hFF) begin
                        kind_next  = in_fnz ? ftdd_pkg::KIND_NAN
                                   : (s_tdata[31] ? ftdd_pkg::KIND_NINF
                                                  : ftdd_pkg::KIND_PINF);
                        state_next = ftdd_pkg::ST_OUT;
                    end else if (s_tdata[30:0] == 31'd0) begin
                        kind_next  = ftdd_pkg::KIND_ZERO;
                        state_next = ftdd_pkg::ST_OUT;
                    end else begin
                        state_next = ftdd_pkg::ST_CHECK;
                    end
                end
            end
            ftdd_pkg::ST_CHECK: begin
                if (steps_left && (mag_reg >= ftdd_pkg::WIN_HIGH_BITS)) begin
                    down_next  = 1'b1;
                    state_next = ftdd_pkg::ST_MUL;
                end else if (steps_left && (mag_reg < ftdd_pkg::WIN_LOW_BITS)) begin
                    down_next  = 1'b0;
                    state_next = ftdd_pkg::ST_MUL;
                end else begin
                    state_next = ftdd_pkg::ST_ROUND;
                end
            end
            ftdd_pkg::ST_MUL: begin
                prod_next  = mul_a * mul_b;
                state_next = ftdd_pkg::ST_PACK;
            end
            ftdd_pkg::ST_PACK: begin
                mag_next   = {1'b0, packed_bits};
                steps_next = steps_reg + 7'd1;
                exp_next   = down_reg ? exp_reg + 8'sd1 : exp_reg - 8'sd1;
                state_next = ftdd_pkg::ST_CHECK;
            end
            ftdd_pkg::ST_ROUND: begin
                mant_next  = round_int;
                state_next = ftdd_pkg::ST_NORM;
            end
            ftdd_pkg::ST_NORM: begin
                if (mant_reg >= ftdd_pkg::WIN_HIGH_INT) begin
                    prod_next  = mul_a * mul_b;
                    state_next = ftdd_pkg::ST_NDIV;
                end else begin
                    if (mant_reg == 25'd0) begin
                        kind_next = ftdd_pkg::KIND_ZERO;
                        exp_next  = 8'sd0;
                    end else begin
                        kind_next = ftdd_pkg::KIND_FINITE;
                    end
                    state_next = ftdd_pkg::ST_OUT;
                end
            end
            ftdd_pkg::ST_NDIV: begin
                mant_next  = {3'd0, prod_reg[56:ftdd_pkg::RECIP_SHIFT]};
                exp_next   = exp_reg + 8'sd1;
                state_next = ftdd_pkg::ST_NORM;
            end
            ftdd_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = ftdd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ftdd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ftdd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        down_reg  <= down_next;
        exp_reg   <= exp_next;
        steps_reg <= steps_next;
        prod_reg  <= prod_next;
        mant_reg  <= mant_next;
        kind_reg  <= kind_next;
    end

    // Result formatting: sign applied to the mantissa only for finite kinds.
    logic [24:0] out_mant;
    logic [6:0]  out_exp;
    assign out_mant = (kind_reg != ftdd_pkg::KIND_FINITE) ? 25'd0
                    : (neg_reg ? (25'd0 - mant_reg) : mant_reg);
    assign out_exp  = (kind_reg != ftdd_pkg::KIND_FINITE) ? 7'd0 : exp_reg[6:0];

    assign s_tready = (state_reg == ftdd_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == ftdd_pkg::ST_OUT);
    assign m_tdata  = {5'd0, out_exp, out_mant, kind_reg};

    // The two channel sides are never open at once.
    `FTDD_ASSERT_IMPLIES(a_excl_ready, aclk, aresetn, s_tready, !m_tvalid, "ready while result pending")
    // An accepted request closes the input side on the next cycle.
    `FTDD_ASSERT_NEXT(a_accept_closes, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input not closed after request")
    // The scaling loop never runs past its budget.
    `FTDD_ASSERT_IMPLIES(a_budget, aclk, aresetn, state_reg == ftdd_pkg::ST_MUL, steps_reg < ftdd_pkg::STEP_BUDGET, "step budget exceeded")
    // A finite result carries a seven-digit magnitude.
    `FTDD_ASSERT_IMPLIES(a_digits, aclk, aresetn, m_tvalid && (kind_reg == ftdd_pkg::KIND_FINITE), (mant_reg >= ftdd_pkg::WIN_LOW_INT) && (mant_reg < ftdd_pkg::WIN_HIGH_INT), "mantissa out of window")

endmodule
